// ----- design/ils_pkg.sv -----
// ----------------------------------------------------------------------------
// ils_pkg
// Shared sizes, codes and the command struct broadcast to the cell row of
// the indexed list store.
// ----------------------------------------------------------------------------
package ils_pkg;

    localparam int CAPACITY = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 7;
    localparam int VAL_W    = 32;
    localparam int LEN_W    = 6;
    localparam int MODE_W   = 3;
    localparam int STAT_W   = 2;
    localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    typedef enum logic [MODE_W-1:0] {
        MODE_READ   = 3'd0,
        MODE_INSERT = 3'd1,
        MODE_FRONT  = 3'd2,
        MODE_APPEND = 3'd3,
        MODE_DELETE = 3'd4
    } mode_t;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // One command per cycle to every cell: shift-in at pos, or close the gap.
    typedef struct packed {
        logic              ins;
        logic              del;
        logic [CNT_W-1:0]  pos;
        logic [VAL_W-1:0]  value;
    } cmd_t;

endpackage

// ----- design/ils_cell.sv -----
// ----------------------------------------------------------------------------
// ils_cell
// One list slot: holds its element, takes from the left neighbor on insert,
// from the right neighbor on delete, and drives the read bus when addressed.
// ----------------------------------------------------------------------------
module ils_cell (
    input  logic                      clk,
    input  logic [ils_pkg::CNT_W-1:0] index,
    input  ils_pkg::cmd_t             cmd,
    input  logic [ils_pkg::VAL_W-1:0] left_data,
    input  logic [ils_pkg::VAL_W-1:0] right_data,
    output logic [ils_pkg::VAL_W-1:0] data,
    output logic [ils_pkg::VAL_W-1:0] rd_data
);

    logic [ils_pkg::VAL_W-1:0] data_reg;
    logic [ils_pkg::VAL_W-1:0] data_next;

    always_comb
    begin
        priority if (cmd.ins && (index > cmd.pos))
        begin
            data_next = left_data;
        end
        else if (cmd.ins && (index == cmd.pos))
        begin
            data_next = cmd.value;
        end
        else if (cmd.del && (index >= cmd.pos))
        begin
            data_next = right_data;
        end
        else
        begin
            data_next = data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data    = data_reg;
    // zero when not addressed so the row can OR the bus together
    assign rd_data = (index == cmd.pos) ? data_reg : '0;

endmodule

// ----- design/ils_chain.sv -----
// ----------------------------------------------------------------------------
// ils_chain
// Row of CAPACITY cells linked to their neighbors, with the OR-combined read
// bus of the addressed cell.
// ----------------------------------------------------------------------------
module ils_chain (
    input  logic                      clk,
    input  ils_pkg::cmd_t             cmd,
    output logic [ils_pkg::VAL_W-1:0] rd_data
);

    logic [ils_pkg::VAL_W-1:0] cell_data [ils_pkg::CAPACITY];
    logic [ils_pkg::VAL_W-1:0] cell_rd   [ils_pkg::CAPACITY];

    for (genvar i = 0; i < ils_pkg::CAPACITY; i++)
    begin : g_cell
        logic [ils_pkg::VAL_W-1:0] left_d;
        logic [ils_pkg::VAL_W-1:0] right_d;

        // missing neighbors tie to own value; only the last cell uses its tie (on delete)
        if (i == 0)
        begin : g_first
            assign left_d = cell_data[i];
        end
        else
        begin : g_left
            assign left_d = cell_data[i-1];
        end

        if (i == ils_pkg::CAPACITY - 1)
        begin : g_last
            assign right_d = cell_data[i];
        end
        else
        begin : g_right
            assign right_d = cell_data[i+1];
        end

        ils_cell u_cell (
            .clk        (clk),
            .index      (ils_pkg::CNT_W'(i)),
            .cmd        (cmd),
            .left_data  (left_d),
            .right_data (right_d),
            .data       (cell_data[i]),
            .rd_data    (cell_rd[i])
        );
    end

    always_comb
    begin
        rd_data = '0;
        for (int k = 0; k < ils_pkg::CAPACITY; k++)
        begin
            rd_data = rd_data | cell_rd[k];
        end
    end

endmodule

// ----- design/indexed_list_store_core.sv -----
// ----------------------------------------------------------------------------
// indexed_list_store_core
// Ordered list of signed 32-bit values with read, insert and delete by
// position, kept in a shifting row of cells.
// ----------------------------------------------------------------------------
//  channel   signals                               transfer
//  command   start, busy, mode, position,          start high, busy low
//            item_value
//  result    done, read_value, read_valid,         done high, one cycle
//            status, length
//
//  One command per clock: busy stays low, the cell row shifts at the edge that
//  accepts the command, and the result appears with done in the next cycle.
//  Reset empties the list at once; cell contents are not cleared.
//  The receiver cannot stall; done is a one-cycle strobe.
// ----------------------------------------------------------------------------
module indexed_list_store_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [ils_pkg::MODE_W-1:0]         mode,
    input  logic signed [ils_pkg::POS_W-1:0]   position,
    input  logic signed [ils_pkg::VAL_W-1:0]   item_value,
    output logic                               done,
    output logic signed [ils_pkg::VAL_W-1:0]   read_value,
    output logic                               read_valid,
    output logic [ils_pkg::STAT_W-1:0]         status,
    output logic [ils_pkg::LEN_W-1:0]          length
);

    logic                        accept;
    logic [ils_pkg::CNT_W-1:0]   count_reg;
    logic [ils_pkg::CNT_W-1:0]   count_next;
    logic                        done_reg;
    logic [ils_pkg::VAL_W-1:0]   rval_reg;
    logic [ils_pkg::VAL_W-1:0]   rval_next;
    logic                        rvalid_reg;
    logic                        rvalid_next;
    ils_pkg::status_t            status_reg;
    ils_pkg::status_t            status_next;
    ils_pkg::cmd_t               cmd;
    logic [ils_pkg::VAL_W-1:0]   rd_bus;

    logic signed [ils_pkg::CMP_W-1:0]           pos_s;
    logic signed [ils_pkg::CMP_W-1:0]           cnt_s;
    logic [ils_pkg::CNT_W-1:0]                  pos_trunc;
    logic                                       in_range;
    logic                                       full;
    logic [ils_pkg::CNT_W+ils_pkg::LEN_W-1:0]   len_wide;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign pos_s     = $signed({{(ils_pkg::CMP_W-ils_pkg::POS_W){position[ils_pkg::POS_W-1]}},
                                position});
    assign cnt_s     = $signed({{(ils_pkg::CMP_W-ils_pkg::CNT_W){1'b0}}, count_reg});
    assign pos_trunc = pos_s[ils_pkg::CNT_W-1:0];
    assign in_range  = !position[ils_pkg::POS_W-1] && (pos_s < cnt_s);
    assign full      = (count_reg == ils_pkg::CNT_W'(ils_pkg::CAPACITY));

    always_comb
    begin
        cmd.ins     = 1'b0;
        cmd.del     = 1'b0;
        cmd.pos     = pos_trunc;
        cmd.value   = item_value;
        count_next  = count_reg;
        rval_next   = '1;
        rvalid_next = 1'b0;
        status_next = ils_pkg::ST_DONE;
        if (accept)
        begin
            unique case (ils_pkg::mode_t'(mode))
                ils_pkg::MODE_READ:
                begin
                    if (in_range)
                    begin
                        rval_next   = rd_bus;
                        rvalid_next = 1'b1;
                    end
                    else
                    begin
                        status_next = ils_pkg::ST_RANGE;
                    end
                end
                ils_pkg::MODE_INSERT:
                begin
                    priority if (pos_s > cnt_s)
                    begin
                        status_next = ils_pkg::ST_RANGE;
                    end
                    else if (full)
                    begin
                        status_next = ils_pkg::ST_FULL;
                    end
                    else
                    begin
                        cmd.ins    = 1'b1;
                        cmd.pos    = position[ils_pkg::POS_W-1] ? '0 : pos_trunc;
                        count_next = count_reg + 1'b1;
                    end
                end
                ils_pkg::MODE_FRONT:
                begin
                    if (full)
                    begin
                        status_next = ils_pkg::ST_FULL;
                    end
                    else
                    begin
                        cmd.ins    = 1'b1;
                        cmd.pos    = '0;
                        count_next = count_reg + 1'b1;
                    end
                end
                ils_pkg::MODE_APPEND:
                begin
                    if (full)
                    begin
                        status_next = ils_pkg::ST_FULL;
                    end
                    else
                    begin
                        cmd.ins    = 1'b1;
                        cmd.pos    = count_reg;
                        count_next = count_reg + 1'b1;
                    end
                end
                ils_pkg::MODE_DELETE:
                begin
                    if (in_range)
                    begin
                        cmd.del    = 1'b1;
                        count_next = count_reg - 1'b1;
                    end
                    else
                    begin
                        status_next = ils_pkg::ST_RANGE;
                    end
                end
                default:
                begin
                    // unused modes change nothing
                end
            endcase
        end
    end

    ils_chain u_chain (
        .clk     (clk),
        .cmd     (cmd),
        .rd_data (rd_bus)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        rval_reg   <= rval_next;
        rvalid_reg <= rvalid_next;
        status_reg <= status_next;
    end

    assign len_wide   = {{ils_pkg::LEN_W{1'b0}}, count_reg};
    assign done       = done_reg;
    assign read_value = $signed(rval_reg);
    assign read_valid = rvalid_reg;
    assign status     = status_reg;
    assign length     = len_wide[ils_pkg::LEN_W-1:0];

    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done)
        else $error("result strobe missing after accepted command");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> !done)
        else $error("result strobe without command");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= ils_pkg::CNT_W'(ils_pkg::CAPACITY))
        else $error("element count above capacity");

    a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == ils_pkg::ST_FULL)) |->
            (count_reg == ils_pkg::CNT_W'(ils_pkg::CAPACITY)))
        else $error("full status with list not full");

    a_valid_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && read_valid) |-> (status == ils_pkg::ST_DONE) && $stable(count_reg))
        else $error("valid read with bad status or changed length");

endmodule

// ----- test/tb_indexed_list_store_core.sv -----
// ----------------------------------------------------------------------------
// tb_indexed_list_store_core
// Self-checking bench for the indexed list store. A shadow list in the bench
// predicts each result from the accepted commands. A monitor compares every
// done strobe against the oldest prediction, field by field. Directed cases
// cover the empty list, insert and read ordering, and a full list. Random
// traffic then alternates growing and shrinking phases with random gaps.
// ----------------------------------------------------------------------------
module tb_indexed_list_store_core;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [ils_pkg::MODE_W-1:0] MODE_FIRST_UNUSED =
        ils_pkg::MODE_W'(ils_pkg::MODE_DELETE + 1);
    localparam int                MODE_LAST         = 2**ils_pkg::MODE_W - 1;
    localparam int                SHOWN_MISMATCHES  = 10;

    typedef struct {
        logic signed [ils_pkg::VAL_W-1:0] value;
        logic                             valid;
        logic [ils_pkg::STAT_W-1:0]       stat;
        logic [ils_pkg::LEN_W-1:0]        len;
    } list_result_t;

    logic                               clk;
    logic                               rst_n;
    logic                               start;
    logic                               busy;
    logic [ils_pkg::MODE_W-1:0]         mode;
    logic signed [ils_pkg::POS_W-1:0]   position;
    logic signed [ils_pkg::VAL_W-1:0]   item_value;
    logic                               done;
    logic signed [ils_pkg::VAL_W-1:0]   read_value;
    logic                               read_valid;
    logic [ils_pkg::STAT_W-1:0]         status;
    logic [ils_pkg::LEN_W-1:0]          length;

    logic signed [ils_pkg::VAL_W-1:0]   stored_values[$];
    list_result_t                       pending_results[$];
    int                                 mismatch_count;
    bit                                 gaps_enabled;

    indexed_list_store_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .mode       (mode),
        .position   (position),
        .item_value (item_value),
        .done       (done),
        .read_value (read_value),
        .read_valid (read_valid),
        .status     (status),
        .length     (length)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2ms;
        $display("TEST FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Shadow list
    // ------------------------------------------------------------------------
    function automatic logic [ils_pkg::STAT_W-1:0] insert_value(
        input int                               at,
        input logic signed [ils_pkg::VAL_W-1:0] val);
        // beyond-length check wins over the full check
        if (at > stored_values.size())
            return ils_pkg::ST_RANGE;
        if (stored_values.size() >= ils_pkg::CAPACITY)
            return ils_pkg::ST_FULL;
        if (at < 0)
            at = 0;
        stored_values.insert(at, val);
        return ils_pkg::ST_DONE;
    endfunction

    function automatic list_result_t apply_list_op(
        input logic [ils_pkg::MODE_W-1:0]       op,
        input logic signed [ils_pkg::POS_W-1:0] pos,
        input logic signed [ils_pkg::VAL_W-1:0] val);
        list_result_t r;
        int           at;
        int           count;
        at      = pos;
        count   = stored_values.size();
        r.value = -1;
        r.valid = 1'b0;
        r.stat  = ils_pkg::ST_DONE;
        case (op)
            ils_pkg::MODE_READ:
            begin
                if (at >= 0 && at < count)
                begin
                    r.value = stored_values[at];
                    r.valid = 1'b1;
                end
                else
                    r.stat = ils_pkg::ST_RANGE;
            end
            ils_pkg::MODE_INSERT: r.stat = insert_value(at, val);
            ils_pkg::MODE_FRONT:  r.stat = insert_value(0, val);
            ils_pkg::MODE_APPEND: r.stat = insert_value(count, val);
            ils_pkg::MODE_DELETE:
            begin
                if (at >= 0 && at < count)
                    stored_values.delete(at);
                else
                    r.stat = ils_pkg::ST_RANGE;
            end
            default: ;
        endcase
        r.len = ils_pkg::LEN_W'(stored_values.size());
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Command side
    // ------------------------------------------------------------------------
    task automatic send_op(input logic [ils_pkg::MODE_W-1:0]       op,
                           input logic signed [ils_pkg::POS_W-1:0] pos,
                           input logic signed [ils_pkg::VAL_W-1:0] val);
        if (gaps_enabled && $urandom_range(0, 99) < 30)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge clk);
        end
        start      <= 1'b1;
        mode       <= op;
        position   <= pos;
        item_value <= val;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        pending_results.push_back(apply_list_op(op, pos, val));
    endtask

    task automatic wait_for_results();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------
    task automatic note_mismatch(input string field,
                                 input logic [ils_pkg::VAL_W-1:0] want,
                                 input logic [ils_pkg::VAL_W-1:0] got);
        mismatch_count++;
        if (mismatch_count <= SHOWN_MISMATCHES)
            $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, field, want, got);
    endtask

    always @(posedge clk)
    begin
        list_result_t want;
        if (rst_n && done !== 1'b0)
        begin
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= SHOWN_MISMATCHES)
                    $display("%0t: result with no command pending, read_value %0h",
                             $realtime, read_value);
            end
            else
            begin
                want = pending_results.pop_front();
                if (read_value !== want.value)
                    note_mismatch("read_value", want.value, read_value);
                if (read_valid !== want.valid)
                    note_mismatch("read_valid", ils_pkg::VAL_W'(want.valid),
                                  ils_pkg::VAL_W'(read_valid));
                if (status !== want.stat)
                    note_mismatch("status", ils_pkg::VAL_W'(want.stat),
                                  ils_pkg::VAL_W'(status));
                if (length !== want.len)
                    note_mismatch("length", ils_pkg::VAL_W'(want.len),
                                  ils_pkg::VAL_W'(length));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    function automatic logic signed [ils_pkg::VAL_W-1:0] pick_value();
        if ($urandom_range(0, 9) == 0)
        begin
            case ($urandom_range(0, 3))
                0:       return {1'b1, {(ils_pkg::VAL_W-1){1'b0}}};
                1:       return {1'b0, {(ils_pkg::VAL_W-1){1'b1}}};
                2:       return '0;
                default: return '1;
            endcase
        end
        return $urandom;
    endfunction

    function automatic logic signed [ils_pkg::POS_W-1:0] pick_position();
        int count;
        int sel;
        count = stored_values.size();
        sel   = $urandom_range(0, 99);
        if (sel < 70)
            return ils_pkg::POS_W'($urandom_range(0, count));
        if (sel < 85)
            return ils_pkg::POS_W'(count + $urandom_range(0, 2) - 1);
        return ils_pkg::POS_W'($urandom_range(0, 2**ils_pkg::POS_W - 1));
    endfunction

    task automatic test_empty_list();
        send_op(ils_pkg::MODE_READ, ils_pkg::POS_W'(0), '0);
        send_op(ils_pkg::MODE_READ, ils_pkg::POS_W'(-1), '0);
        send_op(ils_pkg::MODE_READ, ils_pkg::POS_W'(63), '0);
        send_op(ils_pkg::MODE_READ, ils_pkg::POS_W'(-64), '0);
        send_op(ils_pkg::MODE_DELETE, ils_pkg::POS_W'(0), '0);
        send_op(ils_pkg::MODE_DELETE, ils_pkg::POS_W'(-1), '0);
        send_op(ils_pkg::MODE_INSERT, ils_pkg::POS_W'(1), 32'h1234_5678);
        for (int m = MODE_FIRST_UNUSED; m <= MODE_LAST; m++)
            send_op(ils_pkg::MODE_W'(m), ils_pkg::POS_W'(0), '1);
    endtask

    task automatic test_insert_and_read();
        // negative position lands at the head
        send_op(ils_pkg::MODE_INSERT, ils_pkg::POS_W'(-64),
                {1'b1, {(ils_pkg::VAL_W-1){1'b0}}});
        send_op(ils_pkg::MODE_FRONT, ils_pkg::POS_W'(63),
                {1'b0, {(ils_pkg::VAL_W-1){1'b1}}});
        send_op(ils_pkg::MODE_APPEND, ils_pkg::POS_W'(-64), '0);
        send_op(ils_pkg::MODE_INSERT, ils_pkg::POS_W'(1), '1);
        send_op(ils_pkg::MODE_INSERT, ils_pkg::POS_W'(-1), 32'h5555_5555);
        for (int i = 0; i <= 5; i++)
            send_op(ils_pkg::MODE_READ, ils_pkg::POS_W'(i), '0);
        send_op(ils_pkg::MODE_DELETE, ils_pkg::POS_W'(2), '0);
        send_op(ils_pkg::MODE_DELETE, ils_pkg::POS_W'(3), '0);
        send_op(ils_pkg::MODE_DELETE, ils_pkg::POS_W'(4), '0);
        send_op(ils_pkg::MODE_READ, ils_pkg::POS_W'(2), '0);
    endtask

    task automatic test_full_list();
        while (stored_values.size() < ils_pkg::CAPACITY)
            send_op(ils_pkg::MODE_APPEND, pick_position(), pick_value());
        send_op(ils_pkg::MODE_FRONT, ils_pkg::POS_W'(0), pick_value());
        send_op(ils_pkg::MODE_INSERT, ils_pkg::POS_W'(ils_pkg::CAPACITY), pick_value());
        send_op(ils_pkg::MODE_INSERT, ils_pkg::POS_W'(ils_pkg::CAPACITY + 1), pick_value());
        send_op(ils_pkg::MODE_APPEND, ils_pkg::POS_W'(0), pick_value());
        send_op(ils_pkg::MODE_READ, ils_pkg::POS_W'(ils_pkg::CAPACITY - 1), '0);
        send_op(ils_pkg::MODE_READ, ils_pkg::POS_W'(ils_pkg::CAPACITY), '0);
        send_op(ils_pkg::MODE_DELETE, ils_pkg::POS_W'(ils_pkg::CAPACITY), '0);
        send_op(ils_pkg::MODE_DELETE, ils_pkg::POS_W'(0), '0);
    endtask

    task automatic run_random_phase(input int n_items, input bit growing);
        int                         sel;
        int                         insert_pct;
        logic [ils_pkg::MODE_W-1:0] op;
        insert_pct = growing ? 57 : 20;
        for (int i = 0; i < n_items; i++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 20)
                op = ils_pkg::MODE_READ;
            else if (sel < 20 + insert_pct)
            begin
                case ($urandom_range(0, 3))
                    0, 1:    op = ils_pkg::MODE_INSERT;
                    2:       op = ils_pkg::MODE_FRONT;
                    default: op = ils_pkg::MODE_APPEND;
                endcase
            end
            else if (sel < 95)
                op = ils_pkg::MODE_DELETE;
            else
                op = ils_pkg::MODE_W'($urandom_range(MODE_FIRST_UNUSED, MODE_LAST));
            send_op(op, pick_position(), pick_value());
        end
    endtask

    task automatic test_random_traffic();
        for (int ph = 0; ph < 16; ph++)
        begin
            // hold a long back-to-back stretch in the middle
            gaps_enabled = !(ph == 6 || ph == 7);
            run_random_phase(105, ph % 2 == 0);
            if (ph == 3 || ph == 10)
                wait_for_results();
        end
        gaps_enabled = 1'b1;
    endtask

    initial
    begin
        mismatch_count = 0;
        gaps_enabled   = 1'b1;
        rst_n      <= 1'b0;
        start      <= 1'b0;
        mode       <= ils_pkg::MODE_READ;
        position   <= '0;
        item_value <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_list();
        test_insert_and_read();
        test_full_list();
        wait_for_results();
        test_random_traffic();

        wait_for_results();
        repeat (4) @(posedge clk);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
